// ===== sv/csu_pkg.sv =====
`default_nettype none

package csu_pkg;

  localparam int NumSems   = 16;
  localparam int NumProcs  = 32;

  localparam int CmdW      = 2;
  localparam int SemIdW    = 4;
  localparam int ValueW    = 32;
  localparam int ProcIdW   = 5;
  localparam int CountW    = 31;

  localparam int SemIdxW   = (NumSems > 1) ? $clog2(NumSems) : 1;
  localparam int ProcIdxW  = (NumProcs > 1) ? $clog2(NumProcs) : 1;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [CmdW-1:0] {
    CmdCreate  = 2'd0,
    CmdAcquire = 2'd1,
    CmdRelease = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [SemIdW-1:0]  sem_id;
    logic [ValueW-1:0]  load_value;
    logic [ProcIdW-1:0] caller;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [SemIdW-1:0]  new_id;
    logic               blocked;
    logic               woken_valid;
    logic [ProcIdW-1:0] woken_proc;
  } rsp_t;

endpackage

`default_nettype wire

// ===== sv/csu_req_if.sv =====
`default_nettype none

interface csu_req_if import csu_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    cmd;
  logic [SemIdW-1:0]  sem_id;
  logic [ValueW-1:0]  load_value;
  logic [ProcIdW-1:0] caller;

  modport source (output valid, output cmd, output sem_id, output load_value,
                  output caller, input ready);
  modport sink   (input valid, input cmd, input sem_id, input load_value,
                  input caller, output ready);
endinterface

`default_nettype wire

// ===== sv/csu_rsp_if.sv =====
`default_nettype none

interface csu_rsp_if import csu_pkg::*; ;
  logic               valid;
  logic               ready;
  logic               status;
  logic [SemIdW-1:0]  new_id;
  logic               blocked;
  logic               woken_valid;
  logic [ProcIdW-1:0] woken_proc;

  modport source (output valid, output status, output new_id, output blocked,
                  output woken_valid, output woken_proc, input ready);
  modport sink   (input valid, input status, input new_id, input blocked,
                  input woken_valid, input woken_proc, output ready);
endinterface

`default_nettype wire

// ===== sv/csu_alloc.sv =====
`default_nettype none

module csu_alloc import csu_pkg::*; (
  input  logic [NumSems-1:0]  used_i,
  output logic                found_o,
  output logic [SemIdxW-1:0]  idx_o
);

  // lowest free slot wins
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = NumSems - 1; i >= 0; i--) begin
      if (!used_i[i]) begin
        found_o = 1'b1;
        idx_o   = SemIdxW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/csu_core.sv =====
`default_nettype none

module csu_core import csu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  logic [NumSems-1:0]  used_q;
  logic [NumSems-1:0]  head_v_q;
  logic [NumSems-1:0]  tail_v_q;
  logic [NumProcs-1:0] next_v_q;
  logic [NumProcs-1:0] waiting_q;

  logic [CountW-1:0]   count_q    [NumSems];
  logic [ProcIdxW-1:0] head_idx_q [NumSems];
  logic [ProcIdxW-1:0] tail_idx_q [NumSems];
  logic [ProcIdxW-1:0] next_idx_q [NumProcs];

  logic                free_found;
  logic [SemIdxW-1:0]  free_idx;

  logic [SemIdxW-1:0]  sid;
  logic [ProcIdxW-1:0] who;
  logic                slot_ok;
  logic                caller_ok;
  logic [CountW-1:0]   cnt;
  logic [ProcIdxW-1:0] head;
  logic [ProcIdxW-1:0] tail;

  logic do_create;
  logic do_dec;
  logic do_inc;
  logic do_block;
  logic do_wake;

  csu_alloc u_alloc (
    .used_i  (used_q),
    .found_o (free_found),
    .idx_o   (free_idx)
  );

  assign sid       = req_i.sem_id[SemIdxW-1:0];
  assign who       = req_i.caller[ProcIdxW-1:0];
  assign slot_ok   = (32'(req_i.sem_id) < NumSems) && used_q[sid];
  assign caller_ok = 32'(req_i.caller) < NumProcs;
  assign cnt       = count_q[sid];
  assign head      = head_idx_q[sid];
  assign tail      = tail_idx_q[sid];

  always_comb begin
    rsp_o        = '0;
    rsp_o.status = 1'b1;
    do_create    = 1'b0;
    do_dec       = 1'b0;
    do_inc       = 1'b0;
    do_block     = 1'b0;
    do_wake      = 1'b0;
    case (cmd_e'(req_i.cmd))
      CmdCreate: begin
        if (!req_i.load_value[CountW] && free_found) begin
          do_create    = 1'b1;
          rsp_o.status = 1'b0;
          rsp_o.new_id = SemIdW'(free_idx);
        end
      end
      CmdAcquire: begin
        if (slot_ok) begin
          if (cnt != '0) begin
            do_dec       = 1'b1;
            rsp_o.status = 1'b0;
          end else if (caller_ok && !waiting_q[who]) begin
            do_block      = 1'b1;
            rsp_o.status  = 1'b0;
            rsp_o.blocked = 1'b1;
          end
        end
      end
      CmdRelease: begin
        if (slot_ok) begin
          rsp_o.status = 1'b0;
          if (head_v_q[sid]) begin
            do_wake           = 1'b1;
            rsp_o.woken_valid = 1'b1;
            rsp_o.woken_proc  = ProcIdW'(head);
          end else if (cnt != CountMax) begin
            do_inc = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // list and slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      head_v_q  <= '0;
      tail_v_q  <= '0;
      next_v_q  <= '0;
      waiting_q <= '0;
    end else if (fire_i) begin
      if (do_create) begin
        used_q[free_idx]   <= 1'b1;
        head_v_q[free_idx] <= 1'b0;
        tail_v_q[free_idx] <= 1'b0;
      end
      if (do_block) begin
        waiting_q[who] <= 1'b1;
        next_v_q[who]  <= 1'b0;
        if (tail_v_q[sid]) begin
          next_v_q[tail] <= 1'b1;
        end else begin
          head_v_q[sid] <= 1'b1;
        end
        tail_v_q[sid] <= 1'b1;
      end
      if (do_wake) begin
        head_v_q[sid] <= next_v_q[head];
        if (!next_v_q[head]) begin
          tail_v_q[sid] <= 1'b0;
        end
        next_v_q[head]  <= 1'b0;
        waiting_q[head] <= 1'b0;
      end
    end
  end

  // counts and links, read only behind their flags
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      if (do_create) begin
        count_q[free_idx] <= req_i.load_value[CountW-1:0];
      end
      if (do_dec) begin
        count_q[sid] <= cnt - CountW'(1);
      end
      if (do_inc) begin
        count_q[sid] <= cnt + CountW'(1);
      end
      if (do_block) begin
        if (tail_v_q[sid]) begin
          next_idx_q[tail] <= who;
        end else begin
          head_idx_q[sid] <= who;
        end
        tail_idx_q[sid] <= who;
      end
      if (do_wake) begin
        head_idx_q[sid] <= next_idx_q[head];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/counting_semaphore_unit.sv =====
`default_nettype none

// Counting semaphore table with FIFO wait lists. One command is accepted
// every cycle while the result side keeps up; each command gives exactly one
// result beat. A command goes through an input register, then the table
// lookup and update, then the result register. A create returns the lowest
// free slot; acquire either decrements a positive count or queues the caller;
// release wakes the oldest waiter or increments the count, saturating at
// 2^31-1. Slots are never freed.

module counting_semaphore_unit import csu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  csu_req_if.sink  req_i,
  csu_rsp_if.source rsp_o
);

  logic in_valid_q;
  req_t in_q;
  logic out_valid_q;
  rsp_t out_q;
  rsp_t rsp_d;
  logic advance;
  logic fire;

  assign advance     = !out_valid_q || rsp_o.ready;
  assign fire        = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.cmd        <= req_i.cmd;
      in_q.sem_id     <= req_i.sem_id;
      in_q.load_value <= req_i.load_value;
      in_q.caller     <= req_i.caller;
    end
    if (fire) begin
      out_q <= rsp_d;
    end
  end

  csu_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_q),
    .rsp_o  (rsp_d)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.new_id      = out_q.new_id;
  assign rsp_o.blocked     = out_q.blocked;
  assign rsp_o.woken_valid = out_q.woken_valid;
  assign rsp_o.woken_proc  = out_q.woken_proc;

endmodule

`default_nettype wire

// ===== sv/csu_checker.sv =====
`default_nettype none

module csu_checker import csu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic               status_i,
  input logic [SemIdW-1:0]  new_id_i,
  input logic               blocked_i,
  input logic               woken_valid_i,
  input logic [ProcIdW-1:0] woken_proc_i
);

  // stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
      $stable(new_id_i) && $stable(blocked_i) && $stable(woken_valid_i) &&
      $stable(woken_proc_i))
    else $error("result beat changed while stalled");

  // error beats carry nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i |-> new_id_i == '0 && !blocked_i &&
      !woken_valid_i && woken_proc_i == '0)
    else $error("error result with payload");

  // woken id only with a wake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !woken_valid_i |-> woken_proc_i == '0)
    else $error("woken id without wake");

  // a command either allocates, blocks or wakes, never two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(blocked_i && woken_valid_i) &&
      !(blocked_i && new_id_i != '0) && !(woken_valid_i && new_id_i != '0))
    else $error("conflicting result flags");

endmodule

bind counting_semaphore_unit csu_checker u_csu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .new_id_i      (rsp_o.new_id),
  .blocked_i     (rsp_o.blocked),
  .woken_valid_i (rsp_o.woken_valid),
  .woken_proc_i  (rsp_o.woken_proc)
);

`default_nettype wire
